/* sv/suhl_pkg.sv */
// ----------------------------------------------------------------------------
// suhl_pkg
// Shared types, widths and register indexes of the scan upsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package suhl_pkg;

    localparam int SUHL_MAX_FACTOR  = 16;
    localparam int SUHL_SAMPLE_BITS = 16;
    localparam int SUHL_CFG_IDX_W   = 1;
    localparam int SUHL_CFG_DATA_W  = 5;
    localparam int SUHL_FACTOR_W    = 5;
    localparam int SUHL_FIFO_DEPTH  = 2;

    localparam logic [SUHL_CFG_IDX_W-1:0] REG_FACTOR = 1'b0;
    localparam logic [SUHL_CFG_IDX_W-1:0] REG_MODE   = 1'b1;

    localparam logic [SUHL_FACTOR_W-1:0] FACTOR_RESET = 5'd2;

    typedef struct packed {
        logic [15:0] range_sample;
        logic [15:0] intensity_sample;
        logic        scan_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] range_out;
        logic [15:0] intensity_out;
        logic        last_of_scan;
    } out_item_t;

    // width of one command word between front and back
    function automatic int suhl_cmd_bits(input int sb, input int fw);
        suhl_cmd_bits = 2 * (3 * sb + fw + 1) + fw + 2;
    endfunction

endpackage

`default_nettype wire

/* sv/suhl_div.sv */
// ----------------------------------------------------------------------------
// suhl_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module suhl_div
    import suhl_pkg::*;
#(
    parameter int SB = SUHL_SAMPLE_BITS,
    parameter int FW = SUHL_FACTOR_W
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [SB-1:0] dividend,
    input  wire logic [FW-1:0] divisor,
    output logic               done,
    output logic [SB-1:0]      quot,
    output logic [FW-1:0]      rem
);

    localparam int CW = $clog2(SB);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [SB-1:0] acc_reg;
    logic [FW-1:0] rem_reg;
    logic [FW-1:0] div_reg;

    logic [FW:0]   trial;
    logic [FW:0]   diff;
    logic          ge;
    logic [FW-1:0] rem_next;
    logic [SB-1:0] acc_next;

    always_comb
    begin
        trial    = {rem_reg, acc_reg[SB-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? diff[FW-1:0] : trial[FW-1:0];
        acc_next = {acc_reg[SB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(SB - 1);
                acc_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = acc_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* sv/suhl_front.sv */
// ----------------------------------------------------------------------------
// suhl_front
// Takes samples, keeps the previous pair and builds one command per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module suhl_front
    import suhl_pkg::*;
#(
    parameter int SB    = SUHL_SAMPLE_BITS,
    parameter int FW    = SUHL_FACTOR_W,
    parameter int CMD_W = suhl_cmd_bits(SB, FW)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire in_item_t         item,
    input  wire logic [FW-1:0]    factor,
    input  wire logic             mode,
    output logic                  cmd_push,
    output logic [CMD_W-1:0]      cmd,
    input  wire logic             cmd_full
);

    typedef struct packed {
        logic [SB-1:0] prev;
        logic [SB-1:0] cur;
        logic [SB-1:0] quot;
        logic [FW-1:0] rem;
        logic          neg;
    } chan_t;

    typedef struct packed {
        chan_t         rng;
        chan_t         inten;
        logic [FW-1:0] factor;
        logic          interval;
        logic          last;
    } cmd_t;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} state_t;

    state_t        state_reg;
    cmd_t          cmd_reg;
    logic [SB-1:0] prev_r_reg;
    logic [SB-1:0] prev_i_reg;
    logic          have_prev_reg;

    logic [SB+15:0] r_ext;
    logic [SB+15:0] i_ext;
    logic [SB-1:0]  cur_r;
    logic [SB-1:0]  cur_i;
    logic           neg_r;
    logic           neg_i;
    logic [SB-1:0]  mag_r;
    logic [SB-1:0]  mag_i;
    logic           accept;
    logic           start_div;

    logic          done_r;
    logic          done_i;
    logic [SB-1:0] quot_r;
    logic [SB-1:0] quot_i;
    logic [FW-1:0] rem_r;
    logic [FW-1:0] rem_i;

    always_comb
    begin
        r_ext     = {{SB{1'b0}}, item.range_sample};
        i_ext     = {{SB{1'b0}}, item.intensity_sample};
        cur_r     = r_ext[SB-1:0];
        cur_i     = i_ext[SB-1:0];
        neg_r     = cur_r < prev_r_reg;
        neg_i     = cur_i < prev_i_reg;
        mag_r     = neg_r ? (prev_r_reg - cur_r) : (cur_r - prev_r_reg);
        mag_i     = neg_i ? (prev_i_reg - cur_i) : (cur_i - prev_i_reg);
        full      = state_reg != ST_IDLE;
        accept    = push && !full;
        start_div = accept && have_prev_reg && mode;
        cmd_push  = (state_reg == ST_PUSH) && !cmd_full;
        cmd       = cmd_reg;
    end

    suhl_div #(.SB(SB), .FW(FW)) u_div_rng (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_div),
        .dividend (mag_r),
        .divisor  (factor),
        .done     (done_r),
        .quot     (quot_r),
        .rem      (rem_r)
    );

    suhl_div #(.SB(SB), .FW(FW)) u_div_int (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_div),
        .dividend (mag_i),
        .divisor  (factor),
        .done     (done_i),
        .quot     (quot_i),
        .rem      (rem_i)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            prev_r_reg    <= '0;
            prev_i_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg.rng.prev   <= prev_r_reg;
                        cmd_reg.rng.cur    <= cur_r;
                        cmd_reg.rng.neg    <= neg_r;
                        cmd_reg.rng.quot   <= '0;
                        cmd_reg.rng.rem    <= '0;
                        cmd_reg.inten.prev <= prev_i_reg;
                        cmd_reg.inten.cur  <= cur_i;
                        cmd_reg.inten.neg  <= neg_i;
                        cmd_reg.inten.quot <= '0;
                        cmd_reg.inten.rem  <= '0;
                        cmd_reg.factor     <= factor;
                        cmd_reg.interval   <= have_prev_reg;
                        cmd_reg.last       <= item.scan_end;
                        if (item.scan_end)
                        begin
                            prev_r_reg    <= '0;
                            prev_i_reg    <= '0;
                            have_prev_reg <= 1'b0;
                        end
                        else
                        begin
                            prev_r_reg    <= cur_r;
                            prev_i_reg    <= cur_i;
                            have_prev_reg <= 1'b1;
                        end
                        state_reg <= start_div ? ST_DIV : ST_PUSH;
                    end
                end
                ST_DIV:
                begin
                    if (done_r && done_i)
                    begin
                        cmd_reg.rng.quot   <= quot_r;
                        cmd_reg.rng.rem    <= rem_r;
                        cmd_reg.inten.quot <= quot_i;
                        cmd_reg.inten.rem  <= rem_i;
                        state_reg          <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/suhl_fifo.sv */
// ----------------------------------------------------------------------------
// suhl_fifo
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module suhl_fifo
    import suhl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = SUHL_FIFO_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    logic do_push;
    logic do_pop;

    always_comb
    begin
        full    = count_reg == NW'(DEPTH);
        empty   = count_reg == '0;
        do_push = push && !full;
        do_pop  = pop && !empty;
        rdata   = data_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/suhl_back.sv */
// ----------------------------------------------------------------------------
// suhl_back
// A command: interval points one per cycle unless stalled, then scan-end echo.
// ----------------------------------------------------------------------------
`default_nettype none

module suhl_back
    import suhl_pkg::*;
#(
    parameter int SB    = SUHL_SAMPLE_BITS,
    parameter int FW    = SUHL_FACTOR_W,
    parameter int CMD_W = suhl_cmd_bits(SB, FW)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_empty,
    input  wire logic [CMD_W-1:0] cmd,
    output logic                  cmd_pop,
    output logic                  empty,
    input  wire logic             pop,
    output out_item_t             result
);

    typedef struct packed {
        logic [SB-1:0] prev;
        logic [SB-1:0] cur;
        logic [SB-1:0] quot;
        logic [FW-1:0] rem;
        logic          neg;
    } chan_t;

    typedef struct packed {
        chan_t         rng;
        chan_t         inten;
        logic [FW-1:0] factor;
        logic          interval;
        logic          last;
    } cmd_t;

    typedef enum logic [1:0] {ST_IDLE, ST_POINTS, ST_ECHO} state_t;

    state_t        state_reg;
    cmd_t          cur_reg;
    logic [FW-1:0] k_reg;
    logic [SB-1:0] qr_reg;
    logic [FW-1:0] rr_reg;
    logic [SB-1:0] qi_reg;
    logic [FW-1:0] ri_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;

    cmd_t           cmd_in;
    logic           can_emit;
    logic           emit;
    logic           last_k;
    logic [SB-1:0]  pt_r;
    logic [SB-1:0]  pt_i;
    logic [SB+15:0] pt_r_ext;
    logic [SB+15:0] pt_i_ext;
    logic [SB+15:0] cur_r_ext;
    logic [SB+15:0] cur_i_ext;
    logic [SB-1:0]  qr_next;
    logic [FW-1:0]  rr_next;
    logic [SB-1:0]  qi_next;
    logic [FW-1:0]  ri_next;

    // q + quot and r + rem, with one carry from the remainder into q
    function automatic logic [SB+FW-1:0] step(
        input logic [SB-1:0] q,
        input logic [FW-1:0] r,
        input logic [SB-1:0] quot,
        input logic [FW-1:0] rem,
        input logic [FW-1:0] f
    );
        logic [FW:0]   r_sum;
        logic [FW:0]   r_sub;
        logic [SB-1:0] q_sum;
        r_sum = {1'b0, r} + {1'b0, rem};
        r_sub = r_sum - {1'b0, f};
        q_sum = q + quot;
        if (r_sum >= {1'b0, f})
        begin
            step = {q_sum + 1'b1, r_sub[FW-1:0]};
        end
        else
        begin
            step = {q_sum, r_sum[FW-1:0]};
        end
    endfunction

    always_comb
    begin
        cmd_in             = cmd;
        can_emit           = !out_valid_reg || pop;
        emit               = can_emit && ((state_reg == ST_POINTS) || (state_reg == ST_ECHO));
        cmd_pop            = (state_reg == ST_IDLE) && !cmd_empty;
        last_k             = k_reg == (cur_reg.factor - 1'b1);
        pt_r               = cur_reg.rng.neg ? (cur_reg.rng.prev - qr_reg)
                                             : (cur_reg.rng.prev + qr_reg);
        pt_i               = cur_reg.inten.neg ? (cur_reg.inten.prev - qi_reg)
                                               : (cur_reg.inten.prev + qi_reg);
        pt_r_ext           = {16'h0000, pt_r};
        pt_i_ext           = {16'h0000, pt_i};
        cur_r_ext          = {16'h0000, cur_reg.rng.cur};
        cur_i_ext          = {16'h0000, cur_reg.inten.cur};
        {qr_next, rr_next} = step(qr_reg, rr_reg, cur_reg.rng.quot, cur_reg.rng.rem,
                                  cur_reg.factor);
        {qi_next, ri_next} = step(qi_reg, ri_reg, cur_reg.inten.quot, cur_reg.inten.rem,
                                  cur_reg.factor);
        empty              = !out_valid_reg;
        result             = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            k_reg         <= '0;
            qr_reg        <= '0;
            rr_reg        <= '0;
            qi_reg        <= '0;
            ri_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cur_reg <= cmd_in;
                        k_reg   <= '0;
                        qr_reg  <= '0;
                        rr_reg  <= '0;
                        qi_reg  <= '0;
                        ri_reg  <= '0;
                        if (cmd_in.interval)
                        begin
                            state_reg <= ST_POINTS;
                        end
                        else if (cmd_in.last)
                        begin
                            state_reg <= ST_ECHO;
                        end
                    end
                end
                ST_POINTS:
                begin
                    if (can_emit)
                    begin
                        out_reg.range_out     <= pt_r_ext[15:0];
                        out_reg.intensity_out <= pt_i_ext[15:0];
                        out_reg.last_of_scan  <= 1'b0;
                        k_reg                 <= k_reg + 1'b1;
                        qr_reg                <= qr_next;
                        rr_reg                <= rr_next;
                        qi_reg                <= qi_next;
                        ri_reg                <= ri_next;
                        if (last_k)
                        begin
                            state_reg <= cur_reg.last ? ST_ECHO : ST_IDLE;
                        end
                    end
                end
                ST_ECHO:
                begin
                    if (can_emit)
                    begin
                        out_reg.range_out     <= cur_r_ext[15:0];
                        out_reg.intensity_out <= cur_i_ext[15:0];
                        out_reg.last_of_scan  <= 1'b1;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/scan_upsampler_hold_or_linear_top.sv */
// ----------------------------------------------------------------------------
// scan_upsampler_hold_or_linear_top
// Integer-factor upsampler for range/intensity scans, hold or linear.
// ----------------------------------------------------------------------------
// Each sample that follows another of the same scan yields upsample_factor
// points (1 to MAX_FACTOR, a zero factor acts as 1), one per cycle from the
// back end while the receiver keeps up, and a scan-end sample adds its own
// point marked last. In hold mode the front end skips the divider and is
// full until each command is queued. In linear mode each interval runs
// through a bit-serial divider, and the front end takes no new sample until
// its command is queued; this overlaps with the back end through a
// two-entry command queue. Configuration is written on cfg_valid, always
// ready, and must only change while the block is idle.
`default_nettype none

module scan_upsampler_hold_or_linear_top
    import suhl_pkg::*;
#(
    parameter int MAX_FACTOR  = SUHL_MAX_FACTOR,
    parameter int SAMPLE_BITS = SUHL_SAMPLE_BITS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire in_item_t                   item,
    output logic                            empty,
    input  wire logic                       pop,
    output out_item_t                       result,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [SUHL_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SUHL_CFG_DATA_W-1:0] cfg_data
);

    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int CMD_W = suhl_cmd_bits(SAMPLE_BITS, FW);

    logic [SUHL_FACTOR_W-1:0] factor_reg;
    logic                     mode_reg;

    logic [31:0]      f_wide;
    logic [FW-1:0]    eff_factor;
    logic             cmd_push;
    logic [CMD_W-1:0] cmd_wr;
    logic             cmd_full;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_rd;
    logic             cmd_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_RESET;
            mode_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FACTOR: factor_reg <= cfg_data[SUHL_FACTOR_W-1:0];
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        f_wide = 32'(factor_reg);
        if (f_wide == 32'd0)
        begin
            eff_factor = FW'(1);
        end
        else if (f_wide > 32'(MAX_FACTOR))
        begin
            eff_factor = FW'(MAX_FACTOR);
        end
        else
        begin
            eff_factor = f_wide[FW-1:0];
        end
    end

    suhl_front #(.SB(SAMPLE_BITS), .FW(FW), .CMD_W(CMD_W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .factor   (eff_factor),
        .mode     (mode_reg),
        .cmd_push (cmd_push),
        .cmd      (cmd_wr),
        .cmd_full (cmd_full)
    );

    suhl_fifo #(.WIDTH(CMD_W), .DEPTH(SUHL_FIFO_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wr),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rd),
        .empty (cmd_empty)
    );

    suhl_back #(.SB(SAMPLE_BITS), .FW(FW), .CMD_W(CMD_W)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_rd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

/* sv/suhl_checker.sv */
// ----------------------------------------------------------------------------
// suhl_checker
// Port-level checks of the scan upsampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module suhl_checker
    import suhl_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      push,
    input wire logic      full,
    input wire logic      empty,
    input wire logic      pop,
    input wire out_item_t result,
    input wire logic      cfg_valid,
    input wire logic      cfg_ready
);

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed or vanished while stalled");

    // the front end is busy in the cycle after each accepted request
    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("front end took two requests back to back");

    // out of reset: nothing waiting and ready for input
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> empty && !full)
        else $error("block not idle after reset");

    // configuration writes are never stalled
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind scan_upsampler_hold_or_linear_top suhl_checker u_suhl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hold/linear scan upsampler.
// ----------------------------------------------------------------------------
// Samples are pushed through the input queue port while a scoreboard predicts
// the interval points and scan-end echoes each one should produce. Every
// popped point is compared field by field against the oldest prediction. A
// short directed run covers the field extremes, both modes, and the factor
// edge cases: zero, sixteen, and values above sixteen. It also covers
// single-sample scans. Randomized scans then run in four phases: no idling,
// a mostly idle sender, a mostly stalling receiver, and both. The
// configuration is rewritten at each half phase while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import suhl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 80;

    class point_scoreboard;
        logic [SUHL_FACTOR_W-1:0] factor_reg;
        logic                     mode_reg;
        logic [15:0]              held_range;
        logic [15:0]              held_intensity;
        bit                       held_valid;
        out_item_t                expected_points[$];
        int                       errors;

        function new();
            factor_reg     = FACTOR_RESET;
            mode_reg       = 1'b0;
            held_range     = '0;
            held_intensity = '0;
            held_valid     = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(logic [SUHL_CFG_IDX_W-1:0] idx,
                                logic [SUHL_CFG_DATA_W-1:0] data);
            case (idx)
                REG_FACTOR: factor_reg = data[SUHL_FACTOR_W-1:0];
                REG_MODE:   mode_reg   = data[0];
                default: ;
            endcase
        endfunction

        function logic [15:0] lerp(logic [15:0] a, logic [15:0] b, int k, int f);
            int diff;
            int step;
            diff = int'(b) - int'(a);
            step = (k * diff) / f;
            return 16'(int'(a) + step);
        endfunction

        function void note_sample(in_item_t s);
            int        f;
            out_item_t p;
            if (held_valid)
            begin
                f = int'(factor_reg);
                if (f == 0)
                    f = 1;
                if (f > SUHL_MAX_FACTOR)
                    f = SUHL_MAX_FACTOR;
                for (int k = 0; k < f; k++)
                begin
                    p.range_out     = mode_reg ? lerp(held_range, s.range_sample, k, f)
                                               : held_range;
                    p.intensity_out = mode_reg ? lerp(held_intensity, s.intensity_sample, k, f)
                                               : held_intensity;
                    p.last_of_scan  = 1'b0;
                    expected_points.insert(expected_points.size(), p);
                end
            end
            if (s.scan_end)
            begin
                p.range_out     = s.range_sample;
                p.intensity_out = s.intensity_sample;
                p.last_of_scan  = 1'b1;
                expected_points.insert(expected_points.size(), p);
                held_valid     = 1'b0;
                held_range     = '0;
                held_intensity = '0;
            end
            else
            begin
                held_valid     = 1'b1;
                held_range     = s.range_sample;
                held_intensity = s.intensity_sample;
            end
        endfunction

        function void check_point(out_item_t got);
            out_item_t exp_p;
            if (expected_points.size() == 0)
            begin
                $error("unexpected point: range_out=%0d intensity_out=%0d last_of_scan=%0b",
                       got.range_out, got.intensity_out, got.last_of_scan);
                errors++;
                return;
            end
            exp_p = expected_points.pop_front();
            if (got.range_out !== exp_p.range_out)
            begin
                $error("range_out: expected %0d, actual %0d", exp_p.range_out, got.range_out);
                errors++;
            end
            if (got.intensity_out !== exp_p.intensity_out)
            begin
                $error("intensity_out: expected %0d, actual %0d",
                       exp_p.intensity_out, got.intensity_out);
                errors++;
            end
            if (got.last_of_scan !== exp_p.last_of_scan)
            begin
                $error("last_of_scan: expected %0b, actual %0b",
                       exp_p.last_of_scan, got.last_of_scan);
                errors++;
            end
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       push      = 1'b0;
    logic                       full;
    in_item_t                   item      = '0;
    logic                       empty;
    logic                       pop       = 1'b0;
    out_item_t                  result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [SUHL_CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SUHL_CFG_DATA_W-1:0] cfg_data  = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    point_scoreboard points_sb = new();

    scan_upsampler_hold_or_linear_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        pop = rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                points_sb.check_point(result);
            if ((pop && !empty) || (push && !full) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic in_item_t mk(int r, int i, bit e);
        in_item_t s;
        s.range_sample     = 16'(r);
        s.intensity_sample = 16'(i);
        s.scan_end         = e;
        return s;
    endfunction

    function automatic logic [15:0] random_value();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(in_item_t s);
        do
        begin
            @(negedge clk);
            item = s;
            push = ($urandom_range(99) >= send_idle_pct);
            @(posedge clk);
        end
        while (!(push && !full));
        points_sb.note_sample(s);
    endtask

    task automatic write_reg(logic [SUHL_CFG_IDX_W-1:0] idx,
                             logic [SUHL_CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        points_sb.write_reg(idx, data);
    endtask

    task automatic configure(logic [SUHL_CFG_DATA_W-1:0] factor_val,
                             logic [SUHL_CFG_DATA_W-1:0] mode_val);
        write_reg(REG_FACTOR, factor_val);
        write_reg(REG_MODE, mode_val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait for every predicted point, then let the block settle
    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        while (points_sb.expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    initial
    begin
        int send_idle_by_phase[4];
        int stall_by_phase[4];
        int scan_left;
        bit is_end;

        send_idle_by_phase = '{0, 87, 0, 37};
        stall_by_phase     = '{0, 0, 87, 37};
        scan_left          = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: factor two, hold
        send_sample(mk(100, 200, 1'b0));
        send_sample(mk(300, 400, 1'b0));
        send_sample(mk(0, 65535, 1'b1));
        send_sample(mk(65535, 0, 1'b1));
        send_sample(mk(0, 0, 1'b0));
        send_sample(mk(65535, 65535, 1'b0));
        send_sample(mk(1, 1, 1'b1));
        drain();

        configure(5'd16, 5'h1F);
        send_sample(mk(0, 65535, 1'b0));
        send_sample(mk(65535, 0, 1'b0));
        send_sample(mk(12345, 54321, 1'b1));
        drain();

        // zero factor acts as one
        configure(5'd0, 5'h01);
        send_sample(mk(7, 9, 1'b0));
        send_sample(mk(65535, 0, 1'b1));
        drain();

        // factors above sixteen saturate
        configure(5'd31, 5'h1E);
        send_sample(mk(5, 6, 1'b0));
        send_sample(mk(65535, 65535, 1'b1));
        drain();

        configure(5'd17, 5'h01);
        send_sample(mk(0, 65535, 1'b0));
        send_sample(mk(65535, 0, 1'b0));
        send_sample(mk(1, 65534, 1'b1));
        drain();

        configure(5'd1, 5'h00);
        send_sample(mk(40000, 3, 1'b0));
        send_sample(mk(2, 50000, 1'b1));

        for (int p = 0; p < 4; p++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                drain();
                send_idle_pct = send_idle_by_phase[p];
                stall_pct     = stall_by_phase[p];
                configure(5'($urandom_range(31)), 5'($urandom_range(31)));
                repeat (19)
                begin
                    if (scan_left == 0)
                        scan_left = $urandom_range(1, 8);
                    is_end = (scan_left == 1) || ($urandom_range(19) == 0);
                    scan_left = is_end ? 0 : scan_left - 1;
                    send_sample(mk(random_value(), random_value(), is_end));
                end
            end
        end

        drain();
        if (points_sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
